@@ rtl/lcp_pkg.sv @@
package lcp_pkg;

    localparam int DefLineBufferSize   = 32;
    localparam int DefColourTailLength = 8;

    localparam logic [7:0] CharNul = 8'h00;
    localparam logic [7:0] CharLf  = 8'h0A;
    localparam logic [7:0] CharCr  = 8'h0D;
    localparam logic [7:0] CharS   = 8'h53;
    localparam logic [7:0] CharG   = 8'h47;
    localparam logic [7:0] CharT   = 8'h54;

    typedef enum logic [1:0] {
        REPLY_DONE    = 2'd0,
        REPLY_INVALID = 2'd1,
        REPLY_STATE   = 2'd2
    } reply_code_t;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_DIRECT = 3'd1,
        MODE_STARRY = 3'd2,
        MODE_XMAS   = 3'd3,
        MODE_PARTY  = 3'd4
    } light_mode_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_LINE,
        FR_DISCARD
    } framer_state_t;

    typedef enum logic [0:0] {
        MT_IDLE,
        MT_SCAN
    } matcher_state_t;

    // Command strings, first character in the top byte, padded with zeros at the end.
    localparam int CmdCount  = 6;
    localparam int CmdOff    = 0;
    localparam int CmdStarry = 1;
    localparam int CmdXmas   = 2;
    localparam int CmdParty  = 3;
    localparam int CmdDirect = 4;
    localparam int CmdGet    = 5;
    localparam int CmdBytes  = 15;
    localparam int HexDigits = 6;

    localparam logic [8*CmdBytes-1:0] CmdText [CmdCount] = '{
        {"SetLED Off", CharCr, CharLf, 24'h0},
        {"SetLED STARRY", CharCr, CharLf},
        {"SetLED XMAS", CharCr, CharLf, 16'h0},
        {"SetLED PARTY", CharCr, CharLf, 8'h0},
        {"SetLED DIRECT ", 8'h0},
        {"GetLEDState", CharCr, CharLf, 16'h0}
    };

    localparam int CmdLen [CmdCount] = '{12, 15, 13, 14, 14, 13};

    typedef struct packed {
        logic line_end;
        logic drop_end;
    } lcp_frame_evt_t;

    typedef struct packed {
        logic        valid;
        reply_code_t reply;
        logic        mode_we;
        light_mode_t mode;
        logic        colour_we;
        logic [23:0] colour;
    } lcp_verdict_t;

    function automatic logic [7:0] cmd_char(input logic [2:0] cmd, input logic [3:0] pos);
        logic [8*CmdBytes-1:0] shifted;
        shifted = CmdText[cmd] << {pos, 3'b000};
        return shifted[8*CmdBytes-1 -: 8];
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") d = c - "0";
        else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
        return d[3:0];
    endfunction

endpackage

@@ rtl/lcp_rx_if.sv @@
interface lcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

@@ rtl/lcp_reply_if.sv @@
interface lcp_reply_if;
    logic       valid;
    logic       ready;
    logic [1:0] reply_code;
    logic [2:0] light_mode;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    modport source(output valid, output reply_code, output light_mode, output red_level,
                   output green_level, output blue_level, input ready);
    modport sink(input valid, input reply_code, input light_mode, input red_level,
                 input green_level, input blue_level, output ready);
endinterface

@@ rtl/ascii_led_command_line_parser_top.sv @@
// Channel  Dir  Fields                                                      Accepted when
// rx       in   rx_byte[7:0]                                                valid && ready
// reply    out  reply_code[1:0] light_mode[2:0] red/green/blue_level[7:0]  valid && ready
//
// A byte other than a line-ending LF never holds rx.ready low for the bytes after it.
// An LF that ends a stored line starts a scan of the line RAM, one read a cycle through
// its single read port: the reply is loaded into the output register when the scan
// ends, and rx.ready stays low during the scan.
// rx.ready is also low while a reply waits in the output register and is not taken.
// Reset clears the framer, matcher, mode and colour; the line RAM is not cleared.
module ascii_led_command_line_parser_top #(
    parameter int LINE_BUFFER_SIZE   = lcp_pkg::DefLineBufferSize,
    parameter int COLOUR_TAIL_LENGTH = lcp_pkg::DefColourTailLength
) (
    input  logic               clk,
    input  logic               rst_n,
    lcp_rx_if.sink             rx,
    lcp_reply_if.source        reply
);

    localparam int AW = $clog2(LINE_BUFFER_SIZE);
    localparam int CW = $clog2(LINE_BUFFER_SIZE + 1);

    logic                    accept;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [7:0]              wr_data;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rd_data;
    logic [CW-1:0]           stored;
    logic                    scan_busy;
    lcp_pkg::lcp_frame_evt_t evt;
    lcp_pkg::lcp_verdict_t   verdict;

    lcp_pkg::light_mode_t mode_reg, mode_next;
    logic [23:0]          colour_reg, colour_next;
    logic                 out_valid_reg, out_valid_next;
    lcp_pkg::reply_code_t out_reply_reg;
    lcp_pkg::light_mode_t out_mode_reg;
    logic [23:0]          out_colour_reg;
    logic                 load;
    lcp_pkg::reply_code_t load_reply;

    assign rx.ready = !scan_busy && (!out_valid_reg || reply.ready);
    assign accept   = rx.valid && rx.ready;

    lcp_framer #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .evt     (evt),
        .stored  (stored)
    );

    lcp_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BUFFER_SIZE)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lcp_matcher #(
        .LINE_BUFFER_SIZE   (LINE_BUFFER_SIZE),
        .COLOUR_TAIL_LENGTH (COLOUR_TAIL_LENGTH)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (evt.line_end),
        .stored_in (stored),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (scan_busy),
        .verdict   (verdict)
    );

    always_comb
    begin
        mode_next   = verdict.mode_we ? verdict.mode : mode_reg;
        colour_next = verdict.colour_we ? verdict.colour : colour_reg;
        load        = verdict.valid || evt.drop_end;
        load_reply  = verdict.valid ? verdict.reply : lcp_pkg::REPLY_INVALID;
        out_valid_next = load || (out_valid_reg && !reply.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lcp_pkg::MODE_OFF;
            colour_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            colour_reg    <= colour_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reply_reg  <= load_reply;
            out_mode_reg   <= mode_next;
            out_colour_reg <= colour_next;
        end
    end

    assign reply.valid       = out_valid_reg;
    assign reply.reply_code  = out_reply_reg;
    assign reply.light_mode  = out_mode_reg;
    assign reply.red_level   = out_colour_reg[23:16];
    assign reply.green_level = out_colour_reg[15:8];
    assign reply.blue_level  = out_colour_reg[7:0];

    // A finished scan must find the output register free.
    a_verdict_slot: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> !out_valid_reg)
        else $error("line verdict produced while a reply is still pending");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        evt.line_end |=> scan_busy)
        else $error("line end did not start a scan");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= lcp_pkg::MODE_PARTY)
        else $error("mode register out of range");

    a_colour_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !verdict.valid |=> $stable(colour_reg))
        else $error("colour changed without a line verdict");

endmodule

@@ rtl/lcp_ram.sv @@
module lcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lcp_framer.sv @@
module lcp_framer #(
    parameter int LINE_BUFFER_SIZE = lcp_pkg::DefLineBufferSize,
    localparam int AW = $clog2(LINE_BUFFER_SIZE),
    localparam int CW = $clog2(LINE_BUFFER_SIZE + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              rx_byte,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [7:0]              wr_data,
    output lcp_pkg::lcp_frame_evt_t evt,
    output logic [CW-1:0]           stored
);

    lcp_pkg::framer_state_t state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcp_pkg::FR_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign inc     = count_reg + AW'(1);
    assign stored  = CW'(inc) + CW'(1);
    assign wr_data = rx_byte;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = inc;
        evt        = '0;
        if (accept)
        begin
            unique case (state_reg)
                lcp_pkg::FR_IDLE:
                begin
                    if (rx_byte == lcp_pkg::CharS || rx_byte == lcp_pkg::CharG ||
                        rx_byte == lcp_pkg::CharT)
                    begin
                        state_next = lcp_pkg::FR_LINE;
                        count_next = '0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                    end
                    else if (rx_byte != lcp_pkg::CharCr && rx_byte != lcp_pkg::CharLf)
                    begin
                        state_next = lcp_pkg::FR_DISCARD;
                    end
                end
                lcp_pkg::FR_LINE:
                begin
                    count_next = inc;
                    wr_en      = 1'b1;
                    if (rx_byte == lcp_pkg::CharLf)
                    begin
                        state_next   = lcp_pkg::FR_IDLE;
                        evt.line_end = 1'b1;
                    end
                    else if (inc >= AW'(LINE_BUFFER_SIZE - 1))
                    begin
                        // The buffer is full without a line end: drop the rest of the line.
                        state_next = lcp_pkg::FR_DISCARD;
                    end
                end
                lcp_pkg::FR_DISCARD:
                begin
                    if (rx_byte == lcp_pkg::CharLf)
                    begin
                        state_next   = lcp_pkg::FR_IDLE;
                        evt.drop_end = 1'b1;
                    end
                end
                default:
                begin
                    state_next = lcp_pkg::FR_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lcp_matcher.sv @@
module lcp_matcher #(
    parameter int LINE_BUFFER_SIZE   = lcp_pkg::DefLineBufferSize,
    parameter int COLOUR_TAIL_LENGTH = lcp_pkg::DefColourTailLength,
    localparam int AW = $clog2(LINE_BUFFER_SIZE),
    localparam int CW = $clog2(LINE_BUFFER_SIZE + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CW-1:0]         stored_in,
    output logic [AW-1:0]         rd_addr,
    input  logic [7:0]            rd_data,
    output logic                  busy,
    output lcp_pkg::lcp_verdict_t verdict
);

    lcp_pkg::matcher_state_t state_reg, state_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          pend_reg, pend_next;
    logic [lcp_pkg::CmdCount-1:0] flags_reg, flags_next;
    logic [23:0]   hex_reg, hex_next;
    logic [CW-1:0] len;
    logic          issue;
    logic          done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcp_pkg::MT_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        flags_reg  <= flags_next;
        hex_reg    <= hex_next;
    end

    assign rd_addr = addr_reg[AW-1:0];
    assign busy    = (state_reg == lcp_pkg::MT_SCAN);

    always_comb
    begin
        state_next  = state_reg;
        stored_next = stored_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        pend_next   = 1'b0;
        flags_next  = flags_reg;
        hex_next    = hex_reg;
        len         = stored_reg;
        issue       = 1'b0;
        done        = 1'b0;
        verdict     = '0;
        unique case (state_reg)
            lcp_pkg::MT_IDLE:
            begin
                if (start)
                begin
                    state_next  = lcp_pkg::MT_SCAN;
                    stored_next = stored_in;
                    addr_next   = '0;
                    flags_next  = '1;
                    hex_next    = '0;
                end
            end
            lcp_pkg::MT_SCAN:
            begin
                // One read is issued per cycle; its byte is checked in the next cycle.
                issue = (addr_reg < stored_reg);
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                pend_next = issue;
                pos_next  = addr_reg;
                if (pend_reg)
                begin
                    if (rd_data == lcp_pkg::CharNul)
                    begin
                        // A zero byte ends the line content early.
                        done = 1'b1;
                        len  = pos_reg;
                    end
                    else
                    begin
                        for (int c = 0; c < lcp_pkg::CmdCount; c++)
                        begin
                            if (pos_reg < CW'(lcp_pkg::CmdLen[c]) &&
                                rd_data != lcp_pkg::cmd_char(3'(c), pos_reg[3:0]))
                            begin
                                flags_next[c] = 1'b0;
                            end
                        end
                        if (pos_reg >= CW'(lcp_pkg::CmdLen[lcp_pkg::CmdDirect]) &&
                            pos_reg < CW'(lcp_pkg::CmdLen[lcp_pkg::CmdDirect] +
                                          lcp_pkg::HexDigits))
                        begin
                            hex_next = {hex_reg[19:0], lcp_pkg::hex_digit(rd_data)};
                        end
                        if (pos_reg + CW'(1) == stored_reg)
                        begin
                            done = 1'b1;
                            len  = stored_reg;
                        end
                    end
                end
                if (done)
                begin
                    state_next    = lcp_pkg::MT_IDLE;
                    pend_next     = 1'b0;
                    verdict.valid = 1'b1;
                    verdict.reply = lcp_pkg::REPLY_INVALID;
                    if (flags_next[lcp_pkg::CmdOff] &&
                        len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdOff]))
                    begin
                        verdict.reply   = lcp_pkg::REPLY_DONE;
                        verdict.mode_we = 1'b1;
                        verdict.mode    = lcp_pkg::MODE_OFF;
                    end
                    else if (flags_next[lcp_pkg::CmdStarry] &&
                             len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdStarry]))
                    begin
                        verdict.reply   = lcp_pkg::REPLY_DONE;
                        verdict.mode_we = 1'b1;
                        verdict.mode    = lcp_pkg::MODE_STARRY;
                    end
                    else if (flags_next[lcp_pkg::CmdXmas] &&
                             len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdXmas]))
                    begin
                        verdict.reply   = lcp_pkg::REPLY_DONE;
                        verdict.mode_we = 1'b1;
                        verdict.mode    = lcp_pkg::MODE_XMAS;
                    end
                    else if (flags_next[lcp_pkg::CmdParty] &&
                             len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdParty]))
                    begin
                        verdict.reply   = lcp_pkg::REPLY_DONE;
                        verdict.mode_we = 1'b1;
                        verdict.mode    = lcp_pkg::MODE_PARTY;
                    end
                    else if (flags_next[lcp_pkg::CmdDirect] &&
                             len >= CW'(lcp_pkg::CmdLen[lcp_pkg::CmdDirect]))
                    begin
                        if (len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdDirect] + COLOUR_TAIL_LENGTH))
                        begin
                            verdict.reply     = lcp_pkg::REPLY_DONE;
                            verdict.mode_we   = 1'b1;
                            verdict.mode      = lcp_pkg::MODE_DIRECT;
                            verdict.colour_we = 1'b1;
                            verdict.colour    = hex_next;
                        end
                    end
                    else if (flags_next[lcp_pkg::CmdGet] &&
                             len == CW'(lcp_pkg::CmdLen[lcp_pkg::CmdGet]))
                    begin
                        verdict.reply = lcp_pkg::REPLY_STATE;
                    end
                end
            end
            default:
            begin
                state_next = lcp_pkg::MT_IDLE;
            end
        endcase
    end

endmodule

@@ bench/ascii_led_command_line_parser_top_tb.sv @@
`timescale 1ns / 100ps

typedef struct packed {
    lcp_pkg::reply_code_t code;
    lcp_pkg::light_mode_t mode;
    logic [23:0]          colour;
} led_reply_t;

// Mirrors the line framer and the command decoder, and checks each reply in order.
class led_command_model;
    localparam int BufBytes = lcp_pkg::DefLineBufferSize;
    localparam int TailLen  = lcp_pkg::DefColourTailLength;

    lcp_pkg::framer_state_t fstate;
    int unsigned            last_idx;
    byte unsigned           line_buf [BufBytes];
    lcp_pkg::light_mode_t   mode;
    logic [23:0]            colour;
    led_reply_t             expected_replies [$];
    int unsigned            errors;
    int unsigned            replies_checked;
    int unsigned            colour_updates;

    function new();
        fstate          = lcp_pkg::FR_IDLE;
        last_idx        = 0;
        mode            = lcp_pkg::MODE_OFF;
        colour          = 24'h0;
        errors          = 0;
        replies_checked = 0;
        colour_updates  = 0;
    endfunction

    function int unsigned pending();
        return expected_replies.size();
    endfunction

    // True when plen is at least the length of the text and the line begins with the text.
    function bit starts_with(string txt, int unsigned plen);
        int unsigned i;
        if (plen < txt.len())
            return 1'b0;
        for (i = 0; i < txt.len(); i++)
            if (line_buf[i] != txt[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function bit line_is(string txt, int unsigned len);
        int unsigned want_len;
        want_len = txt.len() + 2;
        return len == want_len && starts_with(txt, len)
            && line_buf[want_len-2] == lcp_pkg::CharCr
            && line_buf[want_len-1] == lcp_pkg::CharLf;
    endfunction

    function logic [3:0] hex_value(byte unsigned c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'h0;
    endfunction

    function lcp_pkg::reply_code_t decode_line();
        int unsigned stored;
        int unsigned len;
        int unsigned plen;
        int unsigned i;
        logic [23:0] value;
        stored = last_idx + 1;
        if (stored > BufBytes)
            stored = BufBytes;
        // Only the part before the first zero byte takes part in the compare.
        len = 0;
        while (len < stored && line_buf[len] != 0)
            len++;
        plen = 14;
        if (line_is("SetLED Off", len))
        begin
            mode = lcp_pkg::MODE_OFF;
            return lcp_pkg::REPLY_DONE;
        end
        if (line_is("SetLED STARRY", len))
        begin
            mode = lcp_pkg::MODE_STARRY;
            return lcp_pkg::REPLY_DONE;
        end
        if (line_is("SetLED XMAS", len))
        begin
            mode = lcp_pkg::MODE_XMAS;
            return lcp_pkg::REPLY_DONE;
        end
        if (line_is("SetLED PARTY", len))
        begin
            mode = lcp_pkg::MODE_PARTY;
            return lcp_pkg::REPLY_DONE;
        end
        if (starts_with("SetLED DIRECT ", len))
        begin
            if (len - plen != TailLen)
                return lcp_pkg::REPLY_INVALID;
            value = 24'h0;
            for (i = 0; i < 6; i++)
                value = {value[19:0], hex_value(line_buf[plen+i])};
            colour = value;
            mode   = lcp_pkg::MODE_DIRECT;
            colour_updates++;
            return lcp_pkg::REPLY_DONE;
        end
        if (line_is("GetLEDState", len))
            return lcp_pkg::REPLY_STATE;
        return lcp_pkg::REPLY_INVALID;
    endfunction

    function void push_reply(lcp_pkg::reply_code_t code);
        led_reply_t r;
        r.code   = code;
        r.mode   = mode;
        r.colour = colour;
        expected_replies.push_back(r);
    endfunction

    function void note_byte(byte unsigned b);
        case (fstate)
            lcp_pkg::FR_LINE:
            begin
                last_idx++;
                if (last_idx < BufBytes)
                    line_buf[last_idx] = b;
                if (b == lcp_pkg::CharLf)
                begin
                    fstate = lcp_pkg::FR_IDLE;
                    push_reply(decode_line());
                end
                else if (last_idx >= BufBytes - 1)
                begin
                    fstate = lcp_pkg::FR_DISCARD;
                end
            end
            lcp_pkg::FR_DISCARD:
            begin
                if (b == lcp_pkg::CharLf)
                begin
                    fstate = lcp_pkg::FR_IDLE;
                    push_reply(lcp_pkg::REPLY_INVALID);
                end
            end
            default:
            begin
                fstate = lcp_pkg::FR_IDLE;
                if (b == lcp_pkg::CharS || b == lcp_pkg::CharG || b == lcp_pkg::CharT)
                begin
                    fstate      = lcp_pkg::FR_LINE;
                    last_idx    = 0;
                    line_buf[0] = b;
                end
                else if (b != lcp_pkg::CharCr && b != lcp_pkg::CharLf)
                begin
                    fstate = lcp_pkg::FR_DISCARD;
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_reply(logic [1:0] code, logic [2:0] m, logic [23:0] rgb);
        led_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: reply with none expected, expected nothing, got code %0h mode %0h %s",
                     $time, code, m, $sformatf("rgb %06h", rgb));
            errors++;
            return;
        end
        want = expected_replies.pop_front();
        replies_checked++;
        compare_field("reply_code", 8'(want.code), 8'(code));
        compare_field("light_mode", 8'(want.mode), 8'(m));
        compare_field("red_level", want.colour[23:16], rgb[23:16]);
        compare_field("green_level", want.colour[15:8], rgb[15:8]);
        compare_field("blue_level", want.colour[7:0], rgb[7:0]);
    endfunction
endclass

module ascii_led_command_line_parser_top_tb;

    localparam int BufBytes = lcp_pkg::DefLineBufferSize;

    logic clk;
    logic rst_n;

    lcp_rx_if    rx_ch ();
    lcp_reply_if reply_ch ();

    ascii_led_command_line_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .reply (reply_ch)
    );

    led_command_model board;
    byte unsigned     tx_bytes [$];
    int unsigned      bytes_sent;
    int unsigned      tx_idle_pct;
    int unsigned      rx_stall_pct;

    string fixed_cmds [7] = '{"SetLED Off", "SetLED STARRY", "SetLED XMAS", "SetLED PARTY",
                              "GetLEDState", "TEST LED", "TEST SRAM"};

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        reply_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && reply_ch.valid && reply_ch.ready)
            board.check_reply(reply_ch.reply_code, reply_ch.light_mode,
                              {reply_ch.red_level, reply_ch.green_level, reply_ch.blue_level});
    end

    function automatic void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        tx_bytes.push_back(lcp_pkg::CharCr);
        tx_bytes.push_back(lcp_pkg::CharLf);
    endfunction

    function automatic byte unsigned any_byte(bit allow_zero);
        byte unsigned c;
        do
            c = 8'($urandom_range(255));
        while (c == lcp_pkg::CharLf || (!allow_zero && c == lcp_pkg::CharNul));
        return c;
    endfunction

    function automatic byte unsigned hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(9) == 0)
            return any_byte(1'b0);
        return digits[$urandom_range(21)];
    endfunction

    // Mostly well-formed commands with random content, the rest noise and broken lines.
    function automatic void queue_random_line();
        int unsigned kind;
        int unsigned start;
        int unsigned n;
        int unsigned i;
        if ($urandom_range(7) == 0)
            tx_bytes.push_back($urandom_range(1) ? lcp_pkg::CharCr : lcp_pkg::CharLf);
        start = tx_bytes.size();
        kind  = $urandom_range(99);
        if (kind < 58)
        begin
            put_text(fixed_cmds[$urandom_range(6)]);
            put_crlf();
        end
        else if (kind < 78)
        begin
            put_text("SetLED DIRECT ");
            n = $urandom_range(9);
            if (n < 7)
            begin
                repeat (6) tx_bytes.push_back(hex_char());
                tx_bytes.push_back(n == 0 ? any_byte(1'b0) : lcp_pkg::CharCr);
                tx_bytes.push_back(lcp_pkg::CharLf);
            end
            else if (n == 7)
            begin
                // Eight tail bytes, then a zero that cuts off the rest of the line.
                repeat (6) tx_bytes.push_back(hex_char());
                repeat (2) tx_bytes.push_back(any_byte(1'b0));
                tx_bytes.push_back(lcp_pkg::CharNul);
                repeat ($urandom_range(3)) tx_bytes.push_back(any_byte(1'b1));
                tx_bytes.push_back(lcp_pkg::CharLf);
            end
            else
            begin
                i = $urandom_range(12);
                if (i == 7)
                    i = 0;
                repeat (i) tx_bytes.push_back(hex_char());
                tx_bytes.push_back(lcp_pkg::CharLf);
            end
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(20)) tx_bytes.push_back(any_byte(1'b1));
            tx_bytes.push_back(lcp_pkg::CharLf);
        end
        else
        begin
            n = $urandom_range(2);
            tx_bytes.push_back(n == 0 ? lcp_pkg::CharS :
                               (n == 1 ? lcp_pkg::CharG : lcp_pkg::CharT));
            repeat ($urandom_range(28, 40)) tx_bytes.push_back(any_byte(1'b1));
            tx_bytes.push_back(lcp_pkg::CharLf);
        end
        if (kind < 78 && $urandom_range(7) == 0)
        begin
            i = start + $urandom_range(tx_bytes.size() - start - 2);
            tx_bytes[i] = 8'($urandom_range(255));
        end
    endfunction

    task automatic send_byte(byte unsigned b);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front());
    endtask

    task automatic run_random(int unsigned upto);
        while (bytes_sent < upto)
        begin
            queue_random_line();
            send_queued();
        end
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #4_000_000;
        $display("ascii_led_command_line_parser_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        int unsigned waited;
        board          = new();
        bytes_sent     = 0;
        tx_idle_pct    = 15;
        rx_stall_pct   = 74;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        reply_ch.ready = 1'b0;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Top byte value and a zero byte in idle both start a discard.
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(lcp_pkg::CharLf);
        put_crlf();
        tx_bytes.push_back(lcp_pkg::CharNul);
        tx_bytes.push_back(lcp_pkg::CharLf);
        put_text("SetLED STARRY");
        put_crlf();
        put_text("SetLED DIRECT 0aF9zZ");
        put_crlf();
        put_text("GetLEDState");
        put_crlf();
        put_text("SetLED DIRECT ffEE11xy");
        tx_bytes.push_back(lcp_pkg::CharNul);
        tx_bytes.push_back(lcp_pkg::CharLf);
        put_text("SetLED DIRECT 12");
        put_crlf();
        put_text("SetLED DIRECT 1234567");
        put_crlf();
        put_text("TEST LED");
        put_crlf();
        put_text("TEST SRAM");
        put_crlf();
        put_text("SetLED XMAS");
        put_crlf();
        put_text("SetLED PARTY");
        put_crlf();
        put_text("SetLED Off");
        put_crlf();
        put_text("SetLED Of");
        tx_bytes.push_back(lcp_pkg::CharNul);
        put_text("f");
        put_crlf();
        // One line just too long to store, and one that fills the buffer exactly.
        put_text("S");
        repeat (BufBytes - 1) put_text("x");
        tx_bytes.push_back(lcp_pkg::CharLf);
        put_text("G");
        repeat (BufBytes - 2) put_text("y");
        tx_bytes.push_back(lcp_pkg::CharLf);
        send_queued();

        run_random(650);
        pause_until_drained();
        tx_idle_pct  = 74;
        rx_stall_pct = 15;
        run_random(1300);
        pause_until_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(1950);
        @(negedge clk);
        rx_ch.valid <= 1'b0;

        waited = 0;
        while (board.pending() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (BufBytes + 8) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t: replies missing, expected %0d more, got none", $time, board.pending());
            board.errors += board.pending();
        end

        $display("Sent %0d bytes under three sender/receiver idle profiles.", bytes_sent);
        $display("Checked %0d replies, %0d of them direct colour updates.",
                 board.replies_checked, board.colour_updates);
        if (board.errors == 0)
            $display("ascii_led_command_line_parser_top_tb: done, clean");
        else
            $display("ascii_led_command_line_parser_top_tb: done, errors");
        $finish;
    end
endmodule
